FILE: rtl/montgomery_modular_alu_assert.svh
// assertion macros for the montgomery alu
// no dependencies
`ifndef MONTGOMERY_MODULAR_ALU_ASSERT_SVH
`define MONTGOMERY_MODULAR_ALU_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MMA_ASSERT_IMPL(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define MMA_ASSERT_NEXT(label, clk, rst_n, cond, nxt) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) else $error("%m failed");
`else
`define MMA_ASSERT_IMPL(label, clk, rst_n, prop)
`define MMA_ASSERT_NEXT(label, clk, rst_n, cond, nxt)
`endif
`endif

FILE: rtl/mma_pkg.sv
// shared types and constants for the montgomery alu
// no dependencies
`default_nettype none
package mma_pkg;
	typedef enum logic [3:0] {
		CMD_TO_MONT = 4'd0, CMD_FROM_MONT = 4'd1, CMD_ADD = 4'd2, CMD_SUB = 4'd3,
		CMD_MUL = 4'd4, CMD_DIV = 4'd5, CMD_POW = 4'd6, CMD_INV = 4'd7,
		CMD_EQUAL = 4'd8
	} cmd_t;

	localparam logic [1:0] CFG_MODULUS = 2'd0;
	localparam logic [1:0] CFG_NEG_INV = 2'd1;
	localparam logic [1:0] CFG_R_SQUARED = 2'd2;

	typedef struct packed {
		logic [3:0]  command;
		logic [30:0] operand_a;
		logic [30:0] operand_b;
		logic [63:0] exponent;
		logic [63:0] signed_value;
	} in_item_t;

	typedef struct packed {
		logic [30:0] result;
		logic        equal;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DIV, ST_TOM_MUL, ST_POW_INIT, ST_POW_MUL, ST_POW_SQR,
		ST_DIV_FIN, ST_SIMPLE, ST_DONE
	} state_t;

	typedef struct packed {
		logic        start;
		logic [31:0] x;
		logic [31:0] y;
	} mul_req_t;
endpackage
`default_nettype wire

FILE: rtl/montgomery_modular_alu.sv
// Each transfer takes a command and gives one result. To_mont runs a
// 64-step bit-serial remainder, then one Montgomery multiply; pow, inverse
// and div run right-to-left square-and-multiply on one shared Montgomery
// multiplier, the exponent of inverse and div having at most 32 bits.
// No new input is taken until the result is taken.
// depends on mma_pkg, mma_mont_mul, mma_divider, montgomery_modular_alu_assert.svh
`default_nettype none
`include "montgomery_modular_alu_assert.svh"
module montgomery_modular_alu #(
	parameter int WORD_WIDTH = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire mma_pkg::in_item_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output mma_pkg::out_item_t      out_data,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [WORD_WIDTH-1:0] cfg_data
);
	mma_pkg::state_t state_q, state_d;
	mma_pkg::in_item_t item_q;
	logic [29:0] modulus_q, r_sq_q;
	logic [31:0] neg_inv_q;
	logic [31:0] acc_q, base_q, aux_q;
	logic [63:0] k_q;
	logic        pend_q;
	logic [31:0] result_q;
	logic        equal_q;
	logic        accept, mul_done, div_done;
	logic [29:0] rem;
	logic [31:0] prod;
	mma_pkg::mul_req_t req;
	logic        div_start;
	logic [63:0] mag;
	logic [31:0] two_m, t_add, t_sub, ra, rb, tom_v;
	logic        sv_neg;

	assign cfg_ready = (state_q == mma_pkg::ST_IDLE);
	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != mma_pkg::ST_IDLE);
	assign out_valid = (state_q == mma_pkg::ST_DONE);
	assign out_data.result = result_q[30:0];
	assign out_data.equal = equal_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= 30'd3;
			neg_inv_q <= 32'd1431655765;
			r_sq_q <= 30'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				mma_pkg::CFG_MODULUS:   modulus_q <= cfg_data[29:0];
				mma_pkg::CFG_NEG_INV:   neg_inv_q <= cfg_data[31:0];
				mma_pkg::CFG_R_SQUARED: r_sq_q <= cfg_data[29:0];
				default: ;
			endcase
		end
	end

	assign sv_neg = item_q.signed_value[63];
	assign mag = in_data.signed_value[63] ? (64'd0 - in_data.signed_value)
		: in_data.signed_value;
	assign tom_v = sv_neg ? ({2'd0, modulus_q} - {2'd0, rem})
		: ({2'd0, rem} + {2'd0, modulus_q});
	assign two_m = {1'b0, modulus_q, 1'b0};
	assign t_add = {1'b0, item_q.operand_a} + {1'b0, item_q.operand_b} - two_m;
	assign t_sub = {1'b0, item_q.operand_a} - {1'b0, item_q.operand_b};
	assign ra = ({1'b0, item_q.operand_a} >= {2'd0, modulus_q})
		? {1'b0, item_q.operand_a} - {2'd0, modulus_q} : {1'b0, item_q.operand_a};
	assign rb = ({1'b0, item_q.operand_b} >= {2'd0, modulus_q})
		? {1'b0, item_q.operand_b} - {2'd0, modulus_q} : {1'b0, item_q.operand_b};

	mma_mont_mul u_mul (
		.clk(clk), .arst_n(arst_n), .req(req), .modulus(modulus_q),
		.neg_inverse(neg_inv_q), .done(mul_done), .prod(prod)
	);

	mma_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(mag),
		.divisor(modulus_q), .done(div_done), .rem(rem)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mma_pkg::ST_IDLE: if (accept) begin
				unique case (in_data.command)
					mma_pkg::CMD_TO_MONT: state_d = mma_pkg::ST_DIV;
					mma_pkg::CMD_FROM_MONT, mma_pkg::CMD_MUL: state_d = mma_pkg::ST_TOM_MUL;
					mma_pkg::CMD_POW, mma_pkg::CMD_INV, mma_pkg::CMD_DIV:
						state_d = mma_pkg::ST_POW_INIT;
					default: state_d = mma_pkg::ST_SIMPLE;
				endcase
			end
			mma_pkg::ST_DIV: if (div_done) state_d = mma_pkg::ST_TOM_MUL;
			mma_pkg::ST_TOM_MUL: if (mul_done) state_d = mma_pkg::ST_SIMPLE;
			mma_pkg::ST_POW_INIT: if (mul_done) state_d = mma_pkg::ST_POW_MUL;
			mma_pkg::ST_POW_MUL: begin
				if (k_q == 64'd0) begin
					state_d = (item_q.command == mma_pkg::CMD_DIV)
						? mma_pkg::ST_DIV_FIN : mma_pkg::ST_SIMPLE;
				end else if (mul_done || !pend_q) begin
					state_d = mma_pkg::ST_POW_SQR;
				end
			end
			mma_pkg::ST_POW_SQR: if (mul_done) state_d = mma_pkg::ST_POW_MUL;
			mma_pkg::ST_DIV_FIN: if (mul_done) state_d = mma_pkg::ST_SIMPLE;
			mma_pkg::ST_SIMPLE: state_d = mma_pkg::ST_DONE;
			mma_pkg::ST_DONE: if (!out_stall) state_d = mma_pkg::ST_IDLE;
			default: state_d = mma_pkg::ST_IDLE;
		endcase
	end

	// multiplier and divider launches
	always_comb begin
		req = '0;
		div_start = 1'b0;
		unique case (state_q)
			mma_pkg::ST_IDLE: ;
			mma_pkg::ST_DIV: ;
			default: ;
		endcase
		if (state_q == mma_pkg::ST_IDLE && accept
			&& in_data.command == mma_pkg::CMD_TO_MONT) begin
			div_start = 1'b1;
		end
		if (state_q != state_d || (state_q == mma_pkg::ST_POW_MUL && pend_q == 1'b0
			&& k_q != 64'd0 && state_d == mma_pkg::ST_POW_MUL)) begin
			unique case (state_d)
				mma_pkg::ST_TOM_MUL: begin
					req.start = 1'b1;
					if (state_q == mma_pkg::ST_DIV) begin
						req.x = tom_v;
						req.y = {2'd0, r_sq_q};
					end else if (in_data.command == mma_pkg::CMD_MUL) begin
						req.x = {1'b0, in_data.operand_a};
						req.y = {1'b0, in_data.operand_b};
					end else begin
						req.x = {1'b0, in_data.operand_a};
						req.y = 32'd1;
					end
				end
				mma_pkg::ST_POW_INIT: begin
					req.start = 1'b1;
					// one reduced modulo the modulus, plus the modulus
					req.x = (modulus_q >= 30'd2) ? {2'd0, modulus_q} + 32'd1
						: {2'd0, modulus_q};
					req.y = {2'd0, r_sq_q};
				end
				mma_pkg::ST_POW_SQR: begin
					req.start = 1'b1;
					req.x = base_q;
					req.y = base_q;
				end
				mma_pkg::ST_POW_MUL: if ((state_q == mma_pkg::ST_POW_SQR) ? k_q[1] : k_q[0]) begin
					req.start = 1'b1;
					req.x = (state_q == mma_pkg::ST_POW_INIT) ? prod : acc_q;
					req.y = (state_q == mma_pkg::ST_POW_SQR) ? prod : base_q;
				end
				mma_pkg::ST_DIV_FIN: begin
					req.start = 1'b1;
					req.x = aux_q;
					req.y = acc_q;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mma_pkg::ST_IDLE;
			pend_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (req.start && state_d == mma_pkg::ST_POW_MUL) begin
				pend_q <= 1'b1;
			end else if (state_q == mma_pkg::ST_POW_MUL && state_d != mma_pkg::ST_POW_MUL) begin
				pend_q <= 1'b0;
			end else if (state_q != mma_pkg::ST_POW_MUL) begin
				pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == mma_pkg::ST_IDLE && accept) begin
			item_q <= in_data;
			aux_q <= {1'b0, in_data.operand_a};
			unique case (in_data.command)
				mma_pkg::CMD_POW: begin
					base_q <= {1'b0, in_data.operand_a};
					k_q <= in_data.exponent;
				end
				mma_pkg::CMD_INV: begin
					base_q <= {1'b0, in_data.operand_a};
					k_q <= {32'd0, {2'd0, modulus_q} - 32'd2};
				end
				default: begin
					base_q <= {1'b0, in_data.operand_b};
					k_q <= {32'd0, {2'd0, modulus_q} - 32'd2};
				end
			endcase
		end
		if (state_q == mma_pkg::ST_POW_INIT && mul_done) begin
			acc_q <= prod;
		end
		if (state_q == mma_pkg::ST_POW_MUL && k_q != 64'd0 && (mul_done || !pend_q)
			&& state_d == mma_pkg::ST_POW_SQR) begin
			if (pend_q) begin
				acc_q <= prod;
			end
		end
		if (state_q == mma_pkg::ST_POW_SQR && mul_done) begin
			base_q <= prod;
			k_q <= {1'b0, k_q[63:1]};
		end
		if ((state_q == mma_pkg::ST_TOM_MUL || state_q == mma_pkg::ST_DIV_FIN) && mul_done) begin
			acc_q <= prod;
		end
		if (state_q == mma_pkg::ST_SIMPLE) begin
			equal_q <= 1'b0;
			unique case (item_q.command)
				mma_pkg::CMD_TO_MONT, mma_pkg::CMD_MUL, mma_pkg::CMD_POW, mma_pkg::CMD_INV,
				mma_pkg::CMD_DIV: result_q <= acc_q;
				mma_pkg::CMD_FROM_MONT: result_q <= (acc_q >= {2'd0, modulus_q})
					? acc_q - {2'd0, modulus_q} : acc_q;
				mma_pkg::CMD_ADD: result_q <= t_add[31] ? t_add + two_m : t_add;
				mma_pkg::CMD_SUB: result_q <= t_sub[31] ? t_sub + two_m : t_sub;
				mma_pkg::CMD_EQUAL: begin
					result_q <= 32'd0;
					equal_q <= (ra == rb);
				end
				default: result_q <= 32'd0;
			endcase
		end
	end

	`MMA_ASSERT_IMPL(a_stall_busy, clk, arst_n, (state_q != mma_pkg::ST_IDLE) |-> in_stall)
	`MMA_ASSERT_NEXT(a_hold_out, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data))
	`MMA_ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, !out_valid)
	`MMA_ASSERT_IMPL(a_cfg_idle, clk, arst_n, cfg_ready |-> !out_valid)
endmodule
`default_nettype wire

FILE: rtl/mma_mont_mul.sv
// multi-cycle montgomery multiplier: product, q, q*m, then sum
// depends on mma_pkg
`default_nettype none
module mma_mont_mul (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire mma_pkg::mul_req_t req,
	input  wire logic [29:0]      modulus,
	input  wire logic [31:0]      neg_inverse,
	output logic                  done,
	output logic [31:0]           prod
);
	logic [2:0]  step_q;
	logic [63:0] p_q;
	logic [31:0] qv_q;
	logic [63:0] qm_q;
	logic [64:0] sum;

	assign sum = {1'b0, p_q} + {1'b0, qm_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 3'd0;
		end else if (req.start) begin
			step_q <= 3'd1;
		end else if (step_q != 3'd0) begin
			step_q <= (step_q == 3'd4) ? 3'd0 : step_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			p_q <= {32'd0, req.x} * {32'd0, req.y};
		end
		if (step_q == 3'd1) begin
			qv_q <= p_q[31:0] * neg_inverse;
		end
		if (step_q == 3'd2) begin
			qm_q <= {32'd0, qv_q} * {34'd0, modulus};
		end
		if (step_q == 3'd3) begin
			prod <= sum[63:32];
		end
	end

	assign done = (step_q == 3'd4);
endmodule
`default_nettype wire

FILE: rtl/mma_divider.sv
// bit-serial 64 by 30 bit remainder unit
// no dependencies
`default_nettype none
module mma_divider (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] dividend,
	input  wire logic [29:0] divisor,
	output logic             done,
	output logic [29:0]      rem
);
	logic [6:0]  cnt_q;
	logic        done_q;
	logic [63:0] sh_q;
	logic [30:0] r_q;
	logic [31:0] trial;
	logic [31:0] diff;

	assign trial = {r_q, sh_q[63]};
	assign diff = trial - {2'd0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 7'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == 7'd1);
			if (start) begin
				cnt_q <= 7'd64;
			end else if (cnt_q != 7'd0) begin
				cnt_q <= cnt_q - 7'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q <= dividend;
			r_q <= 31'd0;
		end else if (cnt_q != 7'd0) begin
			sh_q <= {sh_q[62:0], 1'b0};
			r_q <= diff[31] ? trial[30:0] : diff[30:0];
		end
	end

	assign done = done_q;
	assign rem = (divisor == 30'd0) ? 30'd0 : r_q[29:0];
endmodule
`default_nettype wire
